// ===== rtl/core/handheld_bus_decoder_with_local_regs_top_assert.svh =====
// assertion macros used by the checker module hbd_chk
`ifndef HANDHELD_BUS_DECODER_WITH_LOCAL_REGS_TOP_ASSERT_SVH
`define HANDHELD_BUS_DECODER_WITH_LOCAL_REGS_TOP_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define HBD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, checked while out of reset
`define HBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/hbd_pkg.sv =====
`timescale 1ns / 1ps

package hbd_pkg;

  localparam int unsigned WRAM_DEPTH = 8192;
  localparam int unsigned HRAM_DEPTH = 127;
  localparam int unsigned WRAM_AW    = $clog2(WRAM_DEPTH);
  localparam int unsigned HRAM_AW    = $clog2(HRAM_DEPTH);

  // address map boundaries
  localparam logic [15:0] ADDR_VRAM     = 16'h8000;
  localparam logic [15:0] ADDR_CRAM     = 16'hA000;
  localparam logic [15:0] ADDR_WRAM     = 16'hC000;
  localparam logic [15:0] ADDR_OAM      = 16'hFE00;
  localparam logic [15:0] ADDR_UNUSABLE = 16'hFEA0;
  localparam logic [15:0] ADDR_IO       = 16'hFF00;
  localparam logic [15:0] ADDR_HRAM     = 16'hFF80;
  localparam logic [15:0] ADDR_IE       = 16'hFFFF;

  localparam logic [15:0] ADDR_JOYP     = 16'hFF00;
  localparam logic [15:0] ADDR_SB       = 16'hFF01;
  localparam logic [15:0] ADDR_SC       = 16'hFF02;
  localparam logic [15:0] ADDR_TIMER_LO = 16'hFF04;
  localparam logic [15:0] ADDR_TIMER_HI = 16'hFF07;
  localparam logic [15:0] ADDR_IF       = 16'hFF0F;
  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ADDR_PPU_LO   = 16'hFF40;
  localparam logic [15:0] ADDR_PPU_HI   = 16'hFF4B;

  localparam logic [7:0] IF_RESET      = 8'hE1;
  localparam logic [7:0] IF_READ_MASK  = 8'hE0;
  localparam logic [7:0] IF_WRITE_MASK = 8'h1F;
  localparam logic [7:0] JOYP_IRQ      = 8'h10;
  localparam logic [7:0] SC_READ_VAL   = 8'h7E;
  localparam logic [7:0] SC_SEND_CMD   = 8'h81;
  localparam logic [1:0] ROW_NONE      = 2'b11;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_JOY   = 2'd2,
    MODE_IRQ   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    TGT_LOCAL = 3'd0,
    TGT_ROM   = 3'd1,
    TGT_PPU   = 3'd2,
    TGT_CRAM  = 3'd3,
    TGT_TIMER = 3'd4
  } target_e;

  // which local register drives read data
  typedef enum logic [2:0] {
    RSEL_ZERO = 3'd0,
    RSEL_FF   = 3'd1,
    RSEL_JOYP = 3'd2,
    RSEL_SB   = 3'd3,
    RSEL_SC   = 3'd4,
    RSEL_IF   = 3'd5,
    RSEL_IE   = 3'd6
  } rsel_e;

  typedef struct packed {
    logic               is_wr;
    logic               wram_en;
    logic               hram_en;
    logic [WRAM_AW-1:0] wram_idx;
    logic [HRAM_AW-1:0] hram_idx;
    logic [7:0]         wdata;
    rsel_e              rsel;
    logic               joyp_wr;
    logic               sb_wr;
    logic               if_wr;
    logic               ie_wr;
    logic               joy_upd;
    logic               irq_req;
    logic [3:0]         dpad;
    logic [3:0]         buttons;
    logic [4:0]         irq_bits;
    target_e            target;
    logic [15:0]        fwd_addr;
    logic [7:0]         fwd_data;
    logic               fwd_is_write;
    logic               serial_send;
    logic               dma_start;
  } dec_t;

endpackage

// ===== rtl/core/hbd_if.sv =====
`timescale 1ns / 1ps

interface hbd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [15:0] addr;
  logic [7:0] wdata;
  logic [3:0] dpad_keys;
  logic [3:0] button_keys;
  logic [4:0] irq_bits;

  modport source (
    output valid, mode, addr, wdata, dpad_keys, button_keys, irq_bits,
    input  ready
  );
  modport sink (
    input  valid, mode, addr, wdata, dpad_keys, button_keys, irq_bits,
    output ready
  );
endinterface

interface hbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic [2:0]  target;
  logic [15:0] fwd_addr;
  logic [7:0]  fwd_data;
  logic        fwd_is_write;
  logic        serial_send;
  logic        dma_start;

  modport source (
    output valid, rdata, target, fwd_addr, fwd_data, fwd_is_write, serial_send,
           dma_start,
    input  ready
  );
  modport sink (
    input  valid, rdata, target, fwd_addr, fwd_data, fwd_is_write, serial_send,
           dma_start,
    output ready
  );
endinterface

// ===== rtl/core/hbd_dec.sv =====
`timescale 1ns / 1ps

module hbd_dec
  import hbd_pkg::*;
(
  input  logic [1:0]  mode_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  input  logic [3:0]  dpad_keys_i,
  input  logic [3:0]  button_keys_i,
  input  logic [4:0]  irq_bits_i,
  output dec_t        dec_o
);

  logic wr;

  assign wr = (mode_i == MODE_WRITE);

  always_comb begin
    dec_o              = '0;
    dec_o.rsel         = RSEL_ZERO;
    dec_o.target       = TGT_LOCAL;
    dec_o.is_wr        = wr;
    dec_o.wdata        = wdata_i;
    dec_o.wram_idx     = addr_i[WRAM_AW-1:0];
    dec_o.hram_idx     = addr_i[HRAM_AW-1:0];
    dec_o.dpad         = dpad_keys_i;
    dec_o.buttons      = button_keys_i;
    dec_o.irq_bits     = irq_bits_i;

    unique case (mode_i)
      MODE_JOY: begin
        dec_o.is_wr   = 1'b0;
        dec_o.joy_upd = 1'b1;
      end
      MODE_IRQ: begin
        dec_o.is_wr   = 1'b0;
        dec_o.irq_req = 1'b1;
      end
      MODE_READ, MODE_WRITE: begin
        if (addr_i < ADDR_VRAM) begin
          dec_o.target = TGT_ROM;
        end else if (addr_i < ADDR_CRAM) begin
          dec_o.target = TGT_PPU;
        end else if (addr_i < ADDR_WRAM) begin
          dec_o.target = TGT_CRAM;
        end else if (addr_i < ADDR_OAM) begin
          // work ram and its echo share the low address bits
          dec_o.wram_en = 1'b1;
        end else if (addr_i < ADDR_UNUSABLE) begin
          dec_o.target = TGT_PPU;
        end else if (addr_i < ADDR_IO) begin
          dec_o.rsel = RSEL_ZERO;
        end else if (addr_i < ADDR_HRAM) begin
          if (addr_i == ADDR_JOYP) begin
            if (wr) dec_o.joyp_wr = 1'b1;
            else    dec_o.rsel    = RSEL_JOYP;
          end else if (addr_i == ADDR_SB) begin
            if (wr) dec_o.sb_wr = 1'b1;
            else    dec_o.rsel  = RSEL_SB;
          end else if (addr_i == ADDR_SC) begin
            if (wr) begin
              if (wdata_i == SC_SEND_CMD) begin
                dec_o.serial_send = 1'b1;
                dec_o.rsel        = RSEL_SB;
              end
            end else begin
              dec_o.rsel = RSEL_SC;
            end
          end else if (addr_i >= ADDR_TIMER_LO && addr_i <= ADDR_TIMER_HI) begin
            dec_o.target = TGT_TIMER;
          end else if (addr_i == ADDR_IF) begin
            if (wr) dec_o.if_wr = 1'b1;
            else    dec_o.rsel  = RSEL_IF;
          end else if (addr_i == ADDR_DMA && wr) begin
            dec_o.dma_start = 1'b1;
            dec_o.fwd_data  = wdata_i;
          end else if (addr_i >= ADDR_PPU_LO && addr_i <= ADDR_PPU_HI) begin
            dec_o.target = TGT_PPU;
          end else if (!wr) begin
            // audio and unmapped io
            dec_o.rsel = RSEL_FF;
          end
        end else if (addr_i < ADDR_IE) begin
          dec_o.hram_en = 1'b1;
        end else begin
          if (wr) dec_o.ie_wr = 1'b1;
          else    dec_o.rsel  = RSEL_IE;
        end

        if (dec_o.target != TGT_LOCAL) begin
          dec_o.fwd_addr = addr_i;
          if (wr) begin
            dec_o.fwd_data     = wdata_i;
            dec_o.fwd_is_write = 1'b1;
          end
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/hbd_regs.sv =====
`timescale 1ns / 1ps

module hbd_regs
  import hbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  dec_t       dec_i,
  output logic [7:0] rdata_o
);

  logic [7:0] irq_flags_q, irq_flags_d;
  logic [7:0] irq_enable_q, irq_enable_d;
  logic [1:0] row_select_q, row_select_d;
  logic [3:0] held_dpad_q, held_dpad_d;
  logic [3:0] held_buttons_q, held_buttons_d;
  logic [7:0] serial_byte_q, serial_byte_d;
  logic       new_press;
  logic [7:0] joyp_val;

  assign new_press = |(dec_i.dpad & ~held_dpad_q) | |(dec_i.buttons & ~held_buttons_q);

  always_comb begin
    irq_flags_d    = irq_flags_q;
    irq_enable_d   = irq_enable_q;
    row_select_d   = row_select_q;
    held_dpad_d    = held_dpad_q;
    held_buttons_d = held_buttons_q;
    serial_byte_d  = serial_byte_q;
    if (accept_i) begin
      if (dec_i.joy_upd) begin
        if (new_press) irq_flags_d = irq_flags_q | JOYP_IRQ;
        held_dpad_d    = dec_i.dpad;
        held_buttons_d = dec_i.buttons;
      end
      if (dec_i.irq_req) irq_flags_d = irq_flags_q | {3'b000, dec_i.irq_bits};
      if (dec_i.if_wr)   irq_flags_d = dec_i.wdata & IF_WRITE_MASK;
      if (dec_i.ie_wr)   irq_enable_d = dec_i.wdata;
      if (dec_i.joyp_wr) row_select_d = dec_i.wdata[5:4];
      if (dec_i.sb_wr)   serial_byte_d = dec_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_flags_q    <= IF_RESET;
      irq_enable_q   <= '0;
      row_select_q   <= ROW_NONE;
      held_dpad_q    <= '0;
      held_buttons_q <= '0;
      serial_byte_q  <= '0;
    end else begin
      irq_flags_q    <= irq_flags_d;
      irq_enable_q   <= irq_enable_d;
      row_select_q   <= row_select_d;
      held_dpad_q    <= held_dpad_d;
      held_buttons_q <= held_buttons_d;
      serial_byte_q  <= serial_byte_d;
    end
  end

  // a selected row (bit low) pulls down the columns of its pressed keys
  always_comb begin
    joyp_val = {2'b11, row_select_q, 4'hF};
    if (!row_select_q[0]) joyp_val = joyp_val & ~{4'h0, held_dpad_q};
    if (!row_select_q[1]) joyp_val = joyp_val & ~{4'h0, held_buttons_q};
  end

  always_comb begin
    unique case (dec_i.rsel)
      RSEL_ZERO: rdata_o = 8'h00;
      RSEL_FF:   rdata_o = 8'hFF;
      RSEL_JOYP: rdata_o = joyp_val;
      RSEL_SB:   rdata_o = serial_byte_q;
      RSEL_SC:   rdata_o = SC_READ_VAL;
      RSEL_IF:   rdata_o = irq_flags_q | IF_READ_MASK;
      RSEL_IE:   rdata_o = irq_enable_q;
      default:   rdata_o = 8'h00;
    endcase
  end

endmodule

// ===== rtl/core/hbd_mem.sv =====
`timescale 1ns / 1ps

module hbd_mem
  import hbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  dec_t       dec_i,
  output logic       clr_busy_o,
  output logic [7:0] wram_rdata_o,
  output logic [7:0] hram_rdata_o
);

  logic [7:0] work_ram [WRAM_DEPTH];
  logic [7:0] high_ram [HRAM_DEPTH];

  logic               clr_busy_q, clr_busy_d;
  logic [WRAM_AW-1:0] clr_idx_q, clr_idx_d;
  logic [7:0]         wram_rdata_q;
  logic [7:0]         hram_rdata_q;
  logic               hram_clr;

  // one sweep after reset zeroes both memories
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == WRAM_AW'(WRAM_DEPTH - 1)) clr_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  assign hram_clr = clr_busy_q && (clr_idx_q < WRAM_AW'(HRAM_DEPTH));

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      work_ram[clr_idx_q] <= 8'h00;
    end else if (accept_i && dec_i.wram_en && dec_i.is_wr) begin
      work_ram[dec_i.wram_idx] <= dec_i.wdata;
    end
    if (accept_i && dec_i.wram_en) wram_rdata_q <= work_ram[dec_i.wram_idx];
  end

  always_ff @(posedge clk_i) begin
    if (hram_clr) begin
      high_ram[clr_idx_q[HRAM_AW-1:0]] <= 8'h00;
    end else if (accept_i && dec_i.hram_en && dec_i.is_wr) begin
      high_ram[dec_i.hram_idx] <= dec_i.wdata;
    end
    if (accept_i && dec_i.hram_en) hram_rdata_q <= high_ram[dec_i.hram_idx];
  end

  assign clr_busy_o   = clr_busy_q;
  assign wram_rdata_o = wram_rdata_q;
  assign hram_rdata_o = hram_rdata_q;

endmodule

// ===== rtl/core/handheld_bus_decoder_with_local_regs_top.sv =====
// the result of an item is registered and presented in the cycle after it is accepted
// throughput: one item per cycle while the output is taken and no clearing pass runs
// the output register holds a stalled result; a new item is taken when it drains
// reset: async active low; registers take their reset values at once, then a
// clearing pass over all 8192 work ram entries zeroes work and high ram with input ready low
`timescale 1ns / 1ps

module handheld_bus_decoder_with_local_regs_top
  import hbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  hbd_in_if.sink           in_i,
  hbd_out_if.source        out_o
);

  dec_t       dec;
  logic       accept;
  logic       clr_busy;
  logic [7:0] reg_rdata;
  logic [7:0] wram_rdata;
  logic [7:0] hram_rdata;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  rd_q;
  logic        wram_sel_q;
  logic        hram_sel_q;
  target_e     target_q;
  logic [15:0] fwd_addr_q;
  logic [7:0]  fwd_data_q;
  logic        fwd_is_write_q;
  logic        serial_send_q;
  logic        dma_start_q;

  hbd_dec u_dec (
    .mode_i        (in_i.mode),
    .addr_i        (in_i.addr),
    .wdata_i       (in_i.wdata),
    .dpad_keys_i   (in_i.dpad_keys),
    .button_keys_i (in_i.button_keys),
    .irq_bits_i    (in_i.irq_bits),
    .dec_o         (dec)
  );

  hbd_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .dec_i    (dec),
    .rdata_o  (reg_rdata)
  );

  hbd_mem u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .dec_i        (dec),
    .clr_busy_o   (clr_busy),
    .wram_rdata_o (wram_rdata),
    .hram_rdata_o (hram_rdata)
  );

  assign in_i.ready = !clr_busy && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept)            out_valid_d = 1'b1;
    else if (out_o.ready)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q           <= reg_rdata;
      wram_sel_q     <= dec.wram_en && !dec.is_wr;
      hram_sel_q     <= dec.hram_en && !dec.is_wr;
      target_q       <= dec.target;
      fwd_addr_q     <= dec.fwd_addr;
      fwd_data_q     <= dec.fwd_data;
      fwd_is_write_q <= dec.fwd_is_write;
      serial_send_q  <= dec.serial_send;
      dma_start_q    <= dec.dma_start;
    end
  end

  // ram read data arrives with the item, held by the ram output register
  assign out_o.valid        = out_valid_q;
  assign out_o.rdata        = wram_sel_q ? wram_rdata : (hram_sel_q ? hram_rdata : rd_q);
  assign out_o.target       = target_q;
  assign out_o.fwd_addr     = fwd_addr_q;
  assign out_o.fwd_data     = fwd_data_q;
  assign out_o.fwd_is_write = fwd_is_write_q;
  assign out_o.serial_send  = serial_send_q;
  assign out_o.dma_start    = dma_start_q;

endmodule

// ===== rtl/core/hbd_chk.sv =====
`timescale 1ns / 1ps
`include "handheld_bus_decoder_with_local_regs_top_assert.svh"

module hbd_chk
  import hbd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  target_i,
  input logic [15:0] fwd_addr_i,
  input logic        fwd_is_write_i,
  input logic        serial_send_i,
  input logic        dma_start_i
);

  logic in_acc;
  logic out_stall;
  logic out_local;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_local = (target_i == TGT_LOCAL);

  `HBD_ASSERT_NEXT(a_acc_gives_result, clk_i, rst_ni, in_acc, out_valid_i)
  `HBD_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_stall, out_valid_i && $stable(target_i))
  `HBD_ASSERT_SAME(a_local_no_fwd, clk_i, rst_ni, out_valid_i && out_local, fwd_addr_i == 16'h0000 && !fwd_is_write_i)
  `HBD_ASSERT_SAME(a_flags_local, clk_i, rst_ni, out_valid_i && (serial_send_i || dma_start_i), out_local && !(serial_send_i && dma_start_i))

endmodule

bind handheld_bus_decoder_with_local_regs_top hbd_chk u_hbd_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .target_i       (out_o.target),
  .fwd_addr_i     (out_o.fwd_addr),
  .fwd_is_write_i (out_o.fwd_is_write),
  .serial_send_i  (out_o.serial_send),
  .dma_start_i    (out_o.dma_start)
);

// ===== tb/handheld_bus_decoder_with_local_regs_top_test.sv =====
`timescale 1ns / 1ps

module handheld_bus_decoder_with_local_regs_top_test;
  import hbd_pkg::*;

  localparam logic [15:0] ECHO_BASE      = 16'hE000;
  localparam int          RANDOM_ITEMS   = 500;
  // covers the ram clearing pass after reset plus the longest stalls
  localparam int          WATCHDOG_LIMIT = 40000;
  localparam int          DRAIN_CYCLES   = 4;

  localparam logic [15:0] BOUNDARY_ADDRS [0:23] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000, 16'hDFFF,
    16'hE000, 16'hFDFF, 16'hFE00, 16'hFE9F, 16'hFEA0, 16'hFEFF, 16'hFF03, 16'hFF08,
    16'hFF0E, 16'hFF10, 16'hFF3F, 16'hFF4C, 16'hFF7F, 16'hFF80, 16'hFFFE, 16'hFFFF
  };

  typedef struct packed {
    mode_e       mode;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [3:0]  dpad;
    logic [3:0]  buttons;
    logic [4:0]  irq;
  } access_t;

  typedef struct packed {
    logic [7:0]  rdata;
    target_e     target;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_data;
    logic        fwd_is_write;
    logic        serial_send;
    logic        dma_start;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hbd_in_if  in_if ();
  hbd_out_if out_if ();

  handheld_bus_decoder_with_local_regs_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted memory map state
  logic [7:0] wram_copy [WRAM_DEPTH];
  logic [7:0] hram_copy [HRAM_DEPTH];
  logic [7:0] flags_copy;
  logic [7:0] enable_copy;
  logic [1:0] row_copy;
  logic [3:0] dpad_copy;
  logic [3:0] buttons_copy;
  logic [7:0] serial_copy;

  access_t pending_accesses [$];
  result_t expected_results [$];
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  logic    in_fire        = 1'b0;
  int      burst_left     = 1;
  int      gap_left       = 0;
  logic [7:0] stall_cnt   = 8'd0;
  int      stall_style    = 0;

  function automatic result_t decode_access(input access_t it);
    result_t     r;
    logic        wr;
    logic [15:0] a;
    logic [7:0]  joy;
    r   = '0;
    a   = it.addr;
    wr  = (it.mode == MODE_WRITE);
    joy = 8'h00;
    case (it.mode)
      MODE_JOY: begin
        // a key going down that was not held raises the joypad interrupt
        if (((it.dpad & ~dpad_copy) != 4'h0) || ((it.buttons & ~buttons_copy) != 4'h0))
          flags_copy = flags_copy | JOYP_IRQ;
        dpad_copy    = it.dpad;
        buttons_copy = it.buttons;
      end
      MODE_IRQ: begin
        flags_copy = flags_copy | {3'b000, it.irq};
      end
      default: begin
        if (a < ADDR_VRAM) begin
          r.target = TGT_ROM;
        end else if (a < ADDR_CRAM) begin
          r.target = TGT_PPU;
        end else if (a < ADDR_WRAM) begin
          r.target = TGT_CRAM;
        end else if (a < ADDR_OAM) begin
          logic [12:0] idx;
          idx = (a < ECHO_BASE) ? 13'(a - ADDR_WRAM) : 13'(a - ECHO_BASE);
          if (wr) wram_copy[idx] = it.wdata;
          else r.rdata = wram_copy[idx];
        end else if (a < ADDR_UNUSABLE) begin
          r.target = TGT_PPU;
        end else if (a < ADDR_IO) begin
          r.rdata = 8'h00;
        end else if (a < ADDR_HRAM) begin
          if (a == ADDR_JOYP) begin
            if (wr) begin
              row_copy = it.wdata[5:4];
            end else begin
              joy = {2'b11, row_copy, 4'hF};
              // a low select bit exposes that row, pressed keys read low
              if (!row_copy[0]) joy[3:0] = joy[3:0] & ~dpad_copy;
              if (!row_copy[1]) joy[3:0] = joy[3:0] & ~buttons_copy;
              r.rdata = joy;
            end
          end else if (a == ADDR_SB) begin
            if (wr) serial_copy = it.wdata;
            else r.rdata = serial_copy;
          end else if (a == ADDR_SC) begin
            if (wr) begin
              if (it.wdata == SC_SEND_CMD) begin
                r.serial_send = 1'b1;
                r.rdata       = serial_copy;
              end
            end else begin
              r.rdata = SC_READ_VAL;
            end
          end else if (a >= ADDR_TIMER_LO && a <= ADDR_TIMER_HI) begin
            r.target = TGT_TIMER;
          end else if (a == ADDR_IF) begin
            if (wr) flags_copy = it.wdata & IF_WRITE_MASK;
            else r.rdata = flags_copy | IF_READ_MASK;
          end else if (a == ADDR_DMA && wr) begin
            r.dma_start = 1'b1;
            r.fwd_data  = it.wdata;
          end else if (a >= ADDR_PPU_LO && a <= ADDR_PPU_HI) begin
            r.target = TGT_PPU;
          end else if (!wr) begin
            r.rdata = 8'hFF;
          end
        end else if (a < ADDR_IE) begin
          if (wr) hram_copy[HRAM_AW'(a - ADDR_HRAM)] = it.wdata;
          else r.rdata = hram_copy[HRAM_AW'(a - ADDR_HRAM)];
        end else begin
          if (wr) enable_copy = it.wdata;
          else r.rdata = enable_copy;
        end
        if (r.target != TGT_LOCAL) begin
          r.fwd_addr = a;
          if (wr) begin
            r.fwd_data     = it.wdata;
            r.fwd_is_write = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic access_t make_access(input mode_e m, input logic [15:0] a,
                                          input logic [7:0] d, input logic [3:0] dp,
                                          input logic [3:0] bt, input logic [4:0] irq);
    access_t it;
    it.mode    = m;
    it.addr    = a;
    it.wdata   = d;
    it.dpad    = dp;
    it.buttons = bt;
    it.irq     = irq;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // driver: bursts of items with random gaps, valid held until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        pending_accesses.delete(0);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_accesses.size() > 0) begin
        in_if.valid       <= 1'b1;
        in_if.mode        <= pending_accesses[0].mode;
        in_if.addr        <= pending_accesses[0].addr;
        in_if.wdata       <= pending_accesses[0].wdata;
        in_if.dpad_keys   <= pending_accesses[0].dpad;
        in_if.button_keys <= pending_accesses[0].buttons;
        in_if.irq_bits    <= pending_accesses[0].irq;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: ready follows one of four stall styles, redrawn at random by a free-running counter
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 8'd1;
    if (stall_cnt[5:0] == 6'd0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= ($urandom_range(0, 9) < 7);
      2:       out_if.ready <= (stall_cnt % 3 == 0);
      default: out_if.ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk_i) begin : monitor
    result_t want;
    access_t taken;
    in_fire <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item pending");
        end else begin
          want = expected_results.pop_front();
          if (out_if.rdata !== want.rdata)
            report_mismatch($sformatf("rdata %h, want %h", out_if.rdata, want.rdata));
          if (out_if.target !== want.target)
            report_mismatch($sformatf("target %0d, want %0d", out_if.target, want.target));
          if (out_if.fwd_addr !== want.fwd_addr)
            report_mismatch($sformatf("fwd_addr %h, want %h", out_if.fwd_addr,
                                      want.fwd_addr));
          if (out_if.fwd_data !== want.fwd_data)
            report_mismatch($sformatf("fwd_data %h, want %h", out_if.fwd_data,
                                      want.fwd_data));
          if (out_if.fwd_is_write !== want.fwd_is_write)
            report_mismatch($sformatf("fwd_is_write %b, want %b", out_if.fwd_is_write,
                                      want.fwd_is_write));
          if (out_if.serial_send !== want.serial_send)
            report_mismatch($sformatf("serial_send %b, want %b", out_if.serial_send,
                                      want.serial_send));
          if (out_if.dma_start !== want.dma_start)
            report_mismatch($sformatf("dma_start %b, want %b", out_if.dma_start,
                                      want.dma_start));
        end
      end
      if (in_if.valid && in_if.ready) begin
        taken = make_access(mode_e'(in_if.mode), in_if.addr, in_if.wdata, in_if.dpad_keys,
                            in_if.button_keys, in_if.irq_bits);
        expected_results.push_back(decode_access(taken));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("handheld_bus_decoder_with_local_regs_top regression: fail");
      $finish;
    end
  end

  initial begin
    access_t     it;
    int          sel;
    logic [15:0] a;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_READ;
    in_if.addr        = 16'h0000;
    in_if.wdata       = 8'h00;
    in_if.dpad_keys   = 4'h0;
    in_if.button_keys = 4'h0;
    in_if.irq_bits    = 5'h00;
    out_if.ready      = 1'b0;
    for (int i = 0; i < WRAM_DEPTH; i++) wram_copy[i] = 8'h00;
    for (int i = 0; i < HRAM_DEPTH; i++) hram_copy[i] = 8'h00;
    flags_copy   = IF_RESET;
    enable_copy  = 8'h00;
    row_copy     = ROW_NONE;
    dpad_copy    = 4'h0;
    buttons_copy = 4'h0;
    serial_copy  = 8'h00;

    // directed: edges of most regions and each local special register
    pending_accesses.push_back(make_access(MODE_READ,  16'h0000, 8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, 16'h7FFF, 8'hFF, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  ADDR_VRAM, 8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_CRAM, 8'h5A, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_WRAM, 8'hA5, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  ECHO_BASE, 8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, 16'hFDFF, 8'h3C, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  16'hDFFF, 8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, 16'hFE9F, 8'h11, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, 16'hFEFF, 8'h77, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  ADDR_UNUSABLE, 8'h00, 4'h0, 4'h0,
                                           5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_JOYP, 8'h20, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_JOY,   16'h0000, 8'h00, 4'hF, 4'hF, 5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  ADDR_JOYP, 8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_SB,   8'h42, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_SC, SC_SEND_CMD, 4'h0, 4'h0,
                                           5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  ADDR_SC,   8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_TIMER_HI, 8'h05, 4'h0, 4'h0,
                                           5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_IF,   8'hFF, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_IRQ,   16'h0000, 8'h00, 4'h0, 4'h0, 5'h1F));
    pending_accesses.push_back(make_access(MODE_READ,  ADDR_IF,   8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_DMA,  8'hC1, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  ADDR_DMA,  8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  16'hFF10, 8'h00, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, 16'hFFFE, 8'h9D, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_WRITE, ADDR_IE,   8'h1F, 4'h0, 4'h0, 5'h00));
    pending_accesses.push_back(make_access(MODE_READ,  ADDR_IE,   8'h00, 4'h0, 4'h0, 5'h00));

    // random: addresses clustered so writes and reads land on the same entries
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) it.mode = MODE_READ;
      else if (sel < 80) it.mode = MODE_WRITE;
      else if (sel < 90) it.mode = MODE_JOY;
      else it.mode = MODE_IRQ;
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        a = 16'($urandom);
      end else if (sel < 40) begin
        a = ($urandom_range(0, 1) ? ADDR_WRAM : ECHO_BASE) + 16'($urandom_range(0, 31));
      end else if (sel < 55) begin
        a = ($urandom_range(0, 7) == 0) ? ADDR_IE : ADDR_HRAM + 16'($urandom_range(0, 126));
      end else if (sel < 85) begin
        case ($urandom_range(0, 7))
          0:       a = ADDR_JOYP;
          1:       a = ADDR_SB;
          2:       a = ADDR_SC;
          3:       a = ADDR_IF;
          4:       a = ADDR_DMA;
          5:       a = ADDR_TIMER_LO + 16'($urandom_range(0, 3));
          6:       a = ADDR_PPU_LO + 16'($urandom_range(0, 11));
          default: a = ADDR_IO + 16'($urandom_range(0, 127));
        endcase
      end else begin
        a = BOUNDARY_ADDRS[$urandom_range(0, 23)];
      end
      it.addr  = a;
      it.wdata = 8'($urandom_range(0, 255));
      if (a == ADDR_SC && $urandom_range(0, 1)) it.wdata = SC_SEND_CMD;
      // released keys now and then so later updates press them again
      it.dpad    = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(0, 15));
      it.buttons = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(0, 15));
      it.irq     = 5'($urandom_range(0, 31));
      pending_accesses.push_back(it);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_accesses.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("handheld_bus_decoder_with_local_regs_top regression: pass");
    end else begin
      $display("handheld_bus_decoder_with_local_regs_top regression: fail");
    end
    $finish;
  end

endmodule
